@@ hw/rtl/cps_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and tables for the circular path stepper
package cps_pkg;

  localparam int DEF_CORDIC_STEPS = 20;
  localparam int DEF_FRAC_BITS    = 16;

  localparam int RATE_FRAC = 24;
  localparam int TRIG_FRAC = 24;
  localparam int UNIT_FRAC = 30;

  // cordic angle and vector widths
  localparam int ZW = 34;
  localparam int XW = 34;

  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_CENTER_Z    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_RADIUS      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_START_ANGLE = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SWEEP_ANGLE = 3'd5;
  localparam logic [CFG_IW-1:0] REG_TURN_RATE   = 3'd6;

  typedef struct packed {
    logic load;
    logic step;
  } cps_cord_ctrl_t;

  // atan(2^-i) in degrees, q.24
  function automatic logic [31:0] cps_atan(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      5'd24: v = 32'd57;
      5'd25: v = 32'd29;
      5'd26: v = 32'd14;
      5'd27: v = 32'd7;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] cps_sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/cps_mul.sv @@
`timescale 1ns / 1ps
// shared signed multiplier with registered product
module cps_mul
  import cps_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

@@ hw/rtl/cps_cordic.sv @@
`timescale 1ns / 1ps
// iterative rotation-mode cordic in degrees, one micro-rotation per cycle while step is asserted
module cps_cordic
  import cps_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cps_cord_ctrl_t       ctrl,
  input  logic signed [ZW-1:0] z_init,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic                 last_o
);

  localparam int CNTW = $clog2(CORDIC_STEPS);

  logic [CNTW-1:0]      it_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] da;

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign da = ZW'(signed'({1'b0, cps_atan(5'(it_r))}));

  assign last_o = (it_r == CNTW'(CORDIC_STEPS - 1));
  assign x_o    = x_r;
  assign y_o    = y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else if (ctrl.load) begin
      it_r <= '0;
    end else if (ctrl.step) begin
      it_r <= it_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r <= XW'(signed'({1'b0, CORDIC_GAIN}));
      y_r <= '0;
      z_r <= z_init;
    end else if (ctrl.step) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - da;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + da;
      end
    end
  end

endmodule

@@ hw/rtl/circular_path_stepper_core.sv @@
`timescale 1ns / 1ps
// Circular path stepper: each timestamp advances a rotation by turn_rate times the elapsed
// milliseconds (or restarts it at start_angle on restart and on the first timestamp after
// reset; a finished rotation is no longer advanced) and returns the point center +
// radius*(cos, sin) in the x/z plane, the rotation and a sticky finished flag.
// A result is posted after the rate step, modulo-360 reduction by reciprocal multiplication
// and quadrant fold, one cordic micro-rotation per cycle, the two radius products and the
// output register. The input is ready again in the same cycle the result is posted. The rate
// product, both reduction products and both radius products go through a single shared
// multiplier. The input is not ready while a transaction is being worked on; one finished
// result can wait in the output register while the next transaction is taken, and that
// transaction holds in its last cycle until the waiting result is taken.
module circular_path_stepper_core
  import cps_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,   // now_ms
  input  logic               in_tuser,   // restart
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [127:0]       out_tdata,  // pos_x, pos_y, pos_z, angle
  output logic               out_tuser,  // finished
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int FW = FRAC_BITS + 9;
  localparam int RW = FW + 1;
  localparam int SH = RATE_FRAC - FRAC_BITS;
  localparam int ZSH = TRIG_FRAC - FRAC_BITS;
  localparam logic [FW-1:0] FULL = FW'(360) << FRAC_BITS;
  localparam logic signed [RW-1:0] FULL_S = RW'(FULL);
  localparam logic signed [RW-1:0] HALF_S = RW'(180) <<< FRAC_BITS;
  localparam logic signed [RW-1:0] Q90_S  = RW'(90) <<< FRAC_BITS;
  localparam logic signed [65:0] RATE_RND = (66'sd1 <<< SH) >>> 1;
  localparam logic signed [65:0] UNIT_RND = 66'sd1 <<< (UNIT_FRAC - 1);
  localparam logic signed [65:0] INC_LIM  = 66'sd1 <<< 40;

  // reciprocal of a full turn for the modulo-360 quotient estimate
  localparam int RECIP_SH = 48;
  localparam logic [63:0] FULL64  = 64'(FULL);
  localparam logic [63:0] RECIP64 = ((64'd1 << RECIP_SH) + FULL64 - 64'd1) / FULL64;
  localparam logic [31:0] RECIP   = RECIP64[31:0];

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RATE  = 4'd1;
  localparam logic [3:0] S_UPD   = 4'd2;
  localparam logic [3:0] S_MLD   = 4'd3;
  localparam logic [3:0] S_MOD   = 4'd4;
  localparam logic [3:0] S_QUO   = 4'd5;
  localparam logic [3:0] S_REM   = 4'd6;
  localparam logic [3:0] S_FOLD1 = 4'd7;
  localparam logic [3:0] S_FOLD2 = 4'd8;
  localparam logic [3:0] S_CORD  = 4'd9;
  localparam logic [3:0] S_PX    = 4'd10;
  localparam logic [3:0] S_PZ    = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  logic [31:0] center_x_r;
  logic [31:0] center_y_r;
  logic [31:0] center_z_r;
  logic [30:0] radius_r;
  logic [31:0] start_angle_r;
  logic [31:0] sweep_angle_r;
  logic [31:0] turn_rate_r;

  logic [31:0] now_r;
  logic        restart_r;
  logic [31:0] last_time_r;
  logic [31:0] rotation_r;
  logic        done_flag_r;
  logic        init_pending_r;
  logic        chk_r;

  logic [31:0]          mag_r;
  logic [FW-1:0]        rem_r;
  logic                 rneg_r;
  logic signed [RW-1:0] z1_r;
  logic                 cneg_r;
  logic [31:0]          pos_x_r;
  logic [31:0]          pos_z_r;

  logic [127:0] out_tdata_r;
  logic         out_tuser_r;
  logic         out_tvalid_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;

  cps_cord_ctrl_t       cctrl;
  logic signed [ZW-1:0] z_init;
  logic signed [XW-1:0] cx;
  logic signed [XW-1:0] cy;
  logic                 clast;

  logic signed [65:0] inc_full;
  logic signed [65:0] inc_cl;
  logic signed [65:0] rot_sum;
  logic [31:0]        rot_new;
  logic signed [33:0] tgt;
  logic [32:0]        tgt_abs;
  logic [32:0]        rot_abs;
  logic signed [65:0] mod_d;
  logic signed [RW-1:0] v_half;
  logic signed [RW-1:0] v_q;
  logic                 v_neg;
  logic signed [XW-1:0] ux;
  logic signed [XW-1:0] uz;
  logic signed [65:0]   unit_sh;
  logic signed [35:0]   place_x;
  logic signed [35:0]   place_z;

  cps_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  cps_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (cctrl),
    .z_init (z_init),
    .x_o    (cx),
    .y_o    (cy),
    .last_o (clast)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign ux = cneg_r ? -cx : cx;
  assign uz = cneg_r ? -cy : cy;

  always_comb begin
    mul_a = {2'b00, radius_r};
    mul_b = ux[32:0];
    case (state_r)
      S_RATE: begin
        mul_a = {turn_rate_r[31], turn_rate_r};
        mul_b = {1'b0, now_r - last_time_r};
      end
      S_MOD: begin
        mul_a = {1'b0, mag_r};
        mul_b = {1'b0, RECIP};
      end
      S_QUO: begin
        mul_a = {16'd0, prod[RECIP_SH+16:RECIP_SH]};
        mul_b = 33'sd360;
      end
      S_PZ: begin
        mul_b = uz[32:0];
      end
      default: begin
      end
    endcase
  end

  // rate step
  always_comb begin
    inc_full = (prod + RATE_RND) >>> SH;
    if (inc_full > INC_LIM) begin
      inc_cl = INC_LIM;
    end else if (inc_full < -INC_LIM) begin
      inc_cl = -INC_LIM;
    end else begin
      inc_cl = inc_full;
    end
    rot_sum = 66'(signed'(rotation_r)) + inc_cl;
    if (rot_sum > 66'sd2147483647) begin
      rot_new = 32'h7FFFFFFF;
    end else if (rot_sum < -66'sd2147483648) begin
      rot_new = 32'h80000000;
    end else begin
      rot_new = rot_sum[31:0];
    end
  end

  // finish test
  always_comb begin
    tgt     = 34'(signed'(start_angle_r)) + 34'(signed'(sweep_angle_r));
    tgt_abs = tgt[33] ? 33'(-tgt) : tgt[32:0];
    rot_abs = rotation_r[31] ? 33'(-34'(signed'(rotation_r))) : {1'b0, rotation_r};
  end

  // magnitude minus estimated whole turns, at most one turn below zero
  assign mod_d = signed'({34'd0, mag_r}) - (prod <<< FRAC_BITS);

  // fold into [-90, 90] degrees
  always_comb begin
    v_half = (z1_r >= HALF_S) ? (z1_r - FULL_S) : z1_r;
    v_neg  = 1'b0;
    v_q    = v_half;
    if (v_half > Q90_S) begin
      v_q   = v_half - HALF_S;
      v_neg = 1'b1;
    end else if (v_half < -Q90_S) begin
      v_q   = v_half + HALF_S;
      v_neg = 1'b1;
    end
    z_init = ZW'(v_q) <<< ZSH;
  end

  always_comb begin
    cctrl.load = (state_r == S_FOLD2);
    cctrl.step = (state_r == S_CORD);
  end

  always_comb begin
    unit_sh = (prod + UNIT_RND) >>> UNIT_FRAC;
    place_x = 36'(signed'(center_x_r)) + unit_sh[35:0];
    place_z = 36'(signed'(center_z_r)) + unit_sh[35:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_RATE;
      S_RATE:  state_nxt = S_UPD;
      S_UPD:   state_nxt = S_MLD;
      S_MLD:   state_nxt = S_MOD;
      S_MOD:   state_nxt = S_QUO;
      S_QUO:   state_nxt = S_REM;
      S_REM:   state_nxt = S_FOLD1;
      S_FOLD1: state_nxt = S_FOLD2;
      S_FOLD2: state_nxt = S_CORD;
      S_CORD:  if (clast) state_nxt = S_PX;
      S_PX:    state_nxt = S_PZ;
      S_PZ:    state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      center_z_r    <= '0;
      radius_r      <= '0;
      start_angle_r <= '0;
      sweep_angle_r <= '0;
      turn_rate_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:    center_x_r    <= cfg_wdata;
        REG_CENTER_Y:    center_y_r    <= cfg_wdata;
        REG_CENTER_Z:    center_z_r    <= cfg_wdata;
        REG_RADIUS:      radius_r      <= cfg_wdata[30:0];
        REG_START_ANGLE: start_angle_r <= cfg_wdata;
        REG_SWEEP_ANGLE: sweep_angle_r <= cfg_wdata;
        REG_TURN_RATE:   turn_rate_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      last_time_r    <= '0;
      rotation_r     <= '0;
      done_flag_r    <= 1'b0;
      init_pending_r <= 1'b1;
      chk_r          <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_OUT) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_UPD: begin
          if (restart_r || init_pending_r) begin
            rotation_r     <= start_angle_r;
            last_time_r    <= now_r;
            init_pending_r <= 1'b0;
            chk_r          <= 1'b0;
          end else if (!done_flag_r) begin
            rotation_r  <= rot_new;
            last_time_r <= now_r;
            chk_r       <= 1'b1;
          end else begin
            chk_r <= 1'b0;
          end
        end
        S_MLD: begin
          if (chk_r && (rot_abs >= tgt_abs)) begin
            done_flag_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        now_r     <= in_tdata;
        restart_r <= in_tuser;
      end
      S_MLD: begin
        mag_r  <= rot_abs[31:0];
        rneg_r <= rotation_r[31];
      end
      S_REM: begin
        if (mod_d[65]) begin
          rem_r <= FW'(mod_d + 66'(FULL));
        end else begin
          rem_r <= FW'(mod_d);
        end
      end
      S_FOLD1: begin
        z1_r <= rneg_r ? (FULL_S - RW'(rem_r)) : RW'(rem_r);
      end
      S_FOLD2: begin
        cneg_r <= v_neg;
      end
      S_PZ: begin
        pos_x_r <= cps_sat32(place_x);
      end
      S_FIN: begin
        pos_z_r <= cps_sat32(place_z);
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_r <= {rotation_r, pos_z_r, center_y_r, pos_x_r};
          out_tuser_r <= done_flag_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/cps_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the circular path stepper, bound to the top level
module cps_checker
  import cps_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [31:0]       in_tdata,
  input logic              in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [127:0]      out_tdata,
  input logic              out_tuser,
  input logic              cfg_we,
  input logic [CFG_IW-1:0] cfg_index,
  input logic [31:0]       cfg_wdata
);

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after a transaction");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // a new result only comes out of a transaction in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

endmodule

bind circular_path_stepper_core cps_checker u_cps_checker (.*);

@@ tb/circular_path_stepper_checker.sv @@
`timescale 1ns / 1ps
// checker for the circular path stepper: predicts each point from the timestamps and compares
module circular_path_stepper_checker
  import cps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [31:0]       in_tdata,   // now_ms
  input  logic              in_tuser,   // restart
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [127:0]      out_tdata,  // pos_x, pos_y, pos_z, angle
  input  logic              out_tuser,  // finished
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_wdata,
  output int                fails,
  output int                outstanding
);

  localparam int FRAC = DEF_FRAC_BITS;
  localparam int STEPS = DEF_CORDIC_STEPS;
  localparam longint INC_LIMIT = 64'sd1 <<< 40;

  localparam longint ATAN_DEG [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367, 234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic        finished;
    logic [31:0] angle;
    logic [31:0] pos_z;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } point_t;

  string field_name [5] = '{"pos_x", "pos_y", "pos_z", "angle", "finished"};

  point_t points_due[$];

  longint ctr_x, ctr_y, ctr_z, radius_q, start_q, sweep_q, rate_q;
  logic [31:0] last_ms;
  longint rotation_q;
  logic finished_q, init_due;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // cos and sin in q.30 of an angle in degrees
  function automatic void unit_vector(input longint ang, output longint c, output longint s);
    longint one, full, r, x, y, z, dx, dy;
    logic flip;
    one = 64'sd1 <<< FRAC;
    full = 360 * one;
    flip = 1'b0;
    r = ang % full;
    if (r < 0) r += full;
    if (r >= 180 * one) r -= full;
    if (r > 90 * one) begin
      r -= 180 * one;
      flip = 1'b1;
    end else if (r < -90 * one) begin
      r += 180 * one;
      flip = 1'b1;
    end
    z = r * (64'sd1 <<< (TRIG_FRAC - FRAC));
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_DEG[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_DEG[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] place_on_circle(input longint ctr, input longint dir);
    longint p;
    p = radius_q * dir + (64'sd1 <<< (UNIT_FRAC - 1));
    return 32'(clamp32(ctr + (p >>> UNIT_FRAC)));
  endfunction

  function automatic point_t next_point(input logic [31:0] now, input logic restart);
    point_t pt;
    logic [31:0] gap;
    longint delta, p, inc, c, s;
    if (restart || init_due) begin
      rotation_q = start_q;
      last_ms = now;
      init_due = 1'b0;
    end else if (!finished_q) begin
      gap = now - last_ms;
      delta = longint'({32'd0, gap});
      // round to nearest, ties upward
      p = rate_q * delta + (64'sd1 <<< (RATE_FRAC - FRAC - 1));
      inc = p >>> (RATE_FRAC - FRAC);
      if (inc > INC_LIMIT) inc = INC_LIMIT;
      if (inc < -INC_LIMIT) inc = -INC_LIMIT;
      last_ms = now;
      rotation_q = clamp32(rotation_q + inc);
      if (magnitude(rotation_q) >= magnitude(start_q + sweep_q)) finished_q = 1'b1;
    end
    unit_vector(rotation_q, c, s);
    pt.pos_x = place_on_circle(ctr_x, c);
    pt.pos_y = ctr_y[31:0];
    pt.pos_z = place_on_circle(ctr_z, s);
    pt.angle = rotation_q[31:0];
    pt.finished = finished_q;
    return pt;
  endfunction

  always @(posedge clk) begin
    point_t want;
    logic [159:0] want_bits, got_bits;
    int bad;
    if (!rst_n) begin
      ctr_x = 0;
      ctr_y = 0;
      ctr_z = 0;
      radius_q = 0;
      start_q = 0;
      sweep_q = 0;
      rate_q = 0;
      last_ms = '0;
      rotation_q = 0;
      finished_q = 1'b0;
      init_due = 1'b1;
      points_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_X:    ctr_x = longint'(signed'(cfg_wdata));
          REG_CENTER_Y:    ctr_y = longint'(signed'(cfg_wdata));
          REG_CENTER_Z:    ctr_z = longint'(signed'(cfg_wdata));
          REG_RADIUS:      radius_q = longint'(cfg_wdata[30:0]);
          REG_START_ANGLE: start_q = longint'(signed'(cfg_wdata));
          REG_SWEEP_ANGLE: sweep_q = longint'(signed'(cfg_wdata));
          REG_TURN_RATE:   rate_q = longint'(signed'(cfg_wdata));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) points_due.push_back(next_point(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        got_bits = {31'd0, out_tuser, out_tdata};
        if (points_due.size() == 0) begin
          $display("%0t: transaction with no point due, expected none, actual %h",
                   $time, got_bits[128:0]);
          fails <= fails + 1;
        end else begin
          want = points_due.pop_front();
          want_bits = {31'd0, want};
          bad = 0;
          for (int i = 0; i < 5; i++) begin
            if (want_bits[32*i +: 32] !== got_bits[32*i +: 32]) begin
              $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name[i],
                       want_bits[32*i +: 32], got_bits[32*i +: 32]);
              bad++;
            end
          end
          fails <= fails + bad;
        end
      end
      outstanding <= points_due.size();
    end
  end

endmodule

@@ tb/circular_path_stepper_core_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the circular path stepper: clock, reset, stimulus and verdict
module circular_path_stepper_core_tb;
  import cps_pkg::*;

  localparam int RANDOM_STAMPS = 1000;
  localparam int STALL_LIMIT = 4000;
  localparam int DEG = 65536;
  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;   // now_ms
  logic in_tuser = 1'b0;        // restart
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;      // pos_x, pos_y, pos_z, angle
  logic out_tuser;              // finished
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  int fails;
  int outstanding;
  int send_gap_pct = 9;
  int take_gap_pct = 67;
  int stamps_sent = 0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  circular_path_stepper_core dut (.*);

  circular_path_stepper_checker path_check (.*);

  always @(posedge clk) out_tready <= ($urandom_range(99) >= take_gap_pct);

  // no transaction for too long means the block hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_stamp(input logic [31:0] now, input logic restart);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= now;
    in_tuser <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    stamps_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_path(input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
                           input logic [31:0] rad, input logic [31:0] a0,
                           input logic [31:0] sweep, input logic [31:0] rate);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_START_ANGLE, a0);
    write_reg(REG_SWEEP_ANGLE, sweep);
    write_reg(REG_TURN_RATE, rate);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] t, cx, cy, cz, rad, a0, sweep, rate;
    longint span, r;
    int base, progress, roll;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: first item initializes, zero rate finishes at once
    send_stamp(32'hFFFF_FFFF, 1'b0);
    send_stamp(32'h0000_0000, 1'b0);
    send_stamp(32'h0000_0005, 1'b1);
    drain;

    // quadrant boundaries at 90 degrees per ms
    write_reg(REG_UNUSED, $urandom);
    load_path(32'(10 * DEG), 32'h1234_5678, 32'(-10 * DEG), 32'(100 * DEG), 32'd0,
              32'h7FFF_FFFF, 32'(90 * 2 ** 24));
    send_stamp(32'h0000_0010, 1'b1);
    for (int i = 1; i <= 6; i++) send_stamp(32'h10 + i, 1'b0);
    send_stamp(32'h0000_0016, 1'b0);
    drain;

    // negative steps with a rounding tie
    load_path(32'd0, 32'd0, 32'd0, 32'(100 * DEG), 32'd0, 32'h8000_0000,
              32'(-90 * 2 ** 24 - 128));
    send_stamp(32'hFFFF_FFFE, 1'b1);
    send_stamp(32'hFFFF_FFFF, 1'b0);
    send_stamp(32'h0000_0000, 1'b0);
    send_stamp(32'h0000_0001, 1'b0);
    drain;

    // positive extremes: huge delta saturates rotation and positions
    load_path(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_stamp(32'h8000_0000, 1'b1);
    send_stamp(32'h7FFF_FFFF, 1'b0);
    send_stamp(32'h7FFF_FFFF, 1'b0);
    send_stamp(32'h0000_0000, 1'b1);
    drain;

    // negative extremes: saturates and finishes, restart keeps finished
    load_path(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
              32'h0000_0000, 32'h8000_0000);
    send_stamp(32'h5555_5555, 1'b1);
    send_stamp(32'hAAAA_AAAA, 1'b0);
    send_stamp(32'hAAAA_AAAB, 1'b0);
    send_stamp(32'hAAAA_AAAB, 1'b1);

    base = stamps_sent;
    while (stamps_sent - base < RANDOM_STAMPS) begin
      drain;
      progress = stamps_sent - base;
      if (progress < RANDOM_STAMPS / 3) begin
        send_gap_pct = 9;
        take_gap_pct = 67;
      end else if (progress < 2 * RANDOM_STAMPS / 3) begin
        send_gap_pct = 67;
        take_gap_pct = 9;
      end else begin
        send_gap_pct = 0;
        take_gap_pct = 0;
      end

      roll = $urandom_range(9);
      cx = (roll < 2) ? $urandom : $urandom_range(2000 * DEG) - 1000 * DEG;
      cy = (roll < 2) ? $urandom : $urandom_range(2000 * DEG) - 1000 * DEG;
      cz = (roll < 2) ? $urandom : $urandom_range(2000 * DEG) - 1000 * DEG;
      roll = $urandom_range(9);
      if (roll < 7) rad = $urandom_range(200 * DEG);
      else if (roll == 7) rad = $urandom;
      else if (roll == 8) rad = 32'h7FFF_FFFF;
      else rad = 32'd0;

      a0 = $urandom_range(1440 * DEG) - 720 * DEG;
      sweep = $urandom_range(720 * DEG);
      if ($urandom_range(1)) sweep = -sweep;
      // rate chosen to cover the sweep in a few dozen frames
      span = longint'($urandom_range(5, 40)) * 16;
      r = (longint'(signed'(sweep)) * 256) / span;
      rate = r[31:0];
      roll = $urandom_range(9);
      if (roll == 0) begin
        a0 = $urandom;
        sweep = $urandom;
        rate = $urandom;
      end else if (roll == 1) begin
        rate = 32'd0;
      end else if (roll == 2) begin
        rate = -rate;
      end
      load_path(cx, cy, cz, rad, a0, sweep, rate);

      repeat ($urandom_range(1, 3)) begin
        t = $urandom;
        send_stamp(t, $urandom_range(9) != 0);
        repeat ($urandom_range(4, 40)) begin
          roll = $urandom_range(99);
          if (roll < 90) t = t + $urandom_range(40);
          else if (roll < 95) t = $urandom;
          send_stamp(t, roll >= 96);
        end
      end
    end

    drain;
    repeat (80) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cps_pkg.sv
hw/rtl/cps_mul.sv
hw/rtl/cps_cordic.sv
hw/rtl/circular_path_stepper_core.sv
hw/rtl/cps_checker.sv
tb/circular_path_stepper_checker.sv
tb/circular_path_stepper_core_tb.sv
